// File: design/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// Shared types and constants of the clock page replacer: operation codes,
// datapath micro-operations and the status word returned to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

    localparam logic [1:0] FUNC_VICTIM = 2'd0;
    localparam logic [1:0] FUNC_PIN    = 2'd1;
    localparam logic [1:0] FUNC_UNPIN  = 2'd2;
    localparam logic [1:0] FUNC_SIZE   = 2'd3;

    localparam int          CFG_WIDTH          = 7;
    localparam logic [6:0]  CFG_CAPACITY_RESET = 7'd64;
    localparam logic        REG_CAPACITY       = 1'b0;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_EV_STEP,
        OP_EV_CLEAR,
        OP_TAKE,
        OP_INC,
        OP_SHIFT_DN,
        OP_FIX_VICTIM,
        OP_FIX_PIN,
        OP_SET_REF,
        OP_APPEND,
        OP_PTR_LAST,
        OP_SHIFT_UP,
        OP_INSERT
    } dp_op_t;

    typedef struct packed {
        logic cnt_zero;
        logic ref_set;
        logic match;
        logic src_last;
        logic has_room;
        logic ins_empty;
        logic ins_at_h;
    } dp_status_t;

endpackage

`default_nettype wire

// File: design/crp_ctrl.sv
// ----------------------------------------------------------------------------
// crp_ctrl
// Controller of the clock page replacer: sequences the search, sweep, shift
// and insert steps and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         func,
    input  wire crp_pkg::dp_status_t st,
    output logic                    busy,
    output logic                    done,
    output crp_pkg::dp_op_t         op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EV_START,
        S_EV_RD,
        S_EV_CHK,
        S_RM_START,
        S_RM_RD,
        S_RM_WR,
        S_RM_END,
        S_FD_START,
        S_FD_RD,
        S_FD_CHK,
        S_INS_START,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  func_reg, func_next;
    logic        done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        done_next  = 1'b0;
        op         = crp_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op        = crp_pkg::OP_START;
                    func_next = func;
                    case (func)
                        crp_pkg::FUNC_VICTIM: state_next = S_EV_START;
                        crp_pkg::FUNC_PIN:    state_next = S_FD_START;
                        crp_pkg::FUNC_UNPIN:  state_next = S_FD_START;
                        default:              done_next  = 1'b1;
                    endcase
                end
            end
            S_EV_START:
            begin
                if (st.cnt_zero)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
                else
                begin
                    op         = crp_pkg::OP_EV_STEP;
                    state_next = S_EV_RD;
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                if (st.ref_set)
                begin
                    op         = crp_pkg::OP_EV_CLEAR;
                    state_next = S_EV_RD;
                end
                else
                begin
                    if (func_reg == crp_pkg::FUNC_VICTIM)
                    begin
                        op = crp_pkg::OP_TAKE;
                    end
                    state_next = S_RM_START;
                end
            end
            S_RM_START:
            begin
                if (st.src_last)
                begin
                    state_next = S_RM_END;
                end
                else
                begin
                    op         = crp_pkg::OP_INC;
                    state_next = S_RM_RD;
                end
            end
            S_RM_RD:
            begin
                state_next = S_RM_WR;
            end
            S_RM_WR:
            begin
                op         = crp_pkg::OP_SHIFT_DN;
                state_next = st.src_last ? S_RM_END : S_RM_RD;
            end
            S_RM_END:
            begin
                if (func_reg == crp_pkg::FUNC_PIN)
                begin
                    op = crp_pkg::OP_FIX_PIN;
                end
                else
                begin
                    op = crp_pkg::OP_FIX_VICTIM;
                end
                if (func_reg == crp_pkg::FUNC_UNPIN)
                begin
                    state_next = S_INS_START;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_FD_START:
            begin
                if (st.cnt_zero)
                begin
                    if (func_reg == crp_pkg::FUNC_UNPIN && !st.has_room)
                    begin
                        state_next = S_EV_START;
                    end
                    else
                    begin
                        if (func_reg == crp_pkg::FUNC_UNPIN)
                        begin
                            op = crp_pkg::OP_APPEND;
                        end
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_FD_RD;
                end
            end
            S_FD_RD:
            begin
                state_next = S_FD_CHK;
            end
            S_FD_CHK:
            begin
                if (st.match)
                begin
                    if (func_reg == crp_pkg::FUNC_PIN)
                    begin
                        state_next = S_RM_START;
                    end
                    else
                    begin
                        op         = crp_pkg::OP_SET_REF;
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                    end
                end
                else if (!st.src_last)
                begin
                    op         = crp_pkg::OP_INC;
                    state_next = S_FD_RD;
                end
                else if (func_reg == crp_pkg::FUNC_UNPIN && !st.has_room)
                begin
                    state_next = S_EV_START;
                end
                else
                begin
                    if (func_reg == crp_pkg::FUNC_UNPIN)
                    begin
                        op = crp_pkg::OP_APPEND;
                    end
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_INS_START:
            begin
                if (st.ins_empty)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    op         = crp_pkg::OP_PTR_LAST;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                op         = crp_pkg::OP_SHIFT_UP;
                state_next = st.ins_at_h ? S_INS_PUT : S_INS_RD;
            end
            S_INS_PUT:
            begin
                op         = crp_pkg::OP_INSERT;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            func_reg  <= crp_pkg::FUNC_SIZE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            func_reg  <= func_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// File: design/crp_datapath.sv
// ----------------------------------------------------------------------------
// crp_datapath
// Datapath of the clock page replacer: the slot memory of frame numbers and
// reference bits, the entry count, the clock hand and the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_datapath
#(
    parameter int CAPACITY      = 64,
    parameter int FRAME_ID_BITS = 10
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire crp_pkg::dp_op_t                  op,
    input  wire logic [FRAME_ID_BITS-1:0]         frame_num,
    input  wire logic [crp_pkg::CFG_WIDTH-1:0]    capacity,
    output crp_pkg::dp_status_t                   st,
    output logic                                  found,
    output logic [FRAME_ID_BITS-1:0]              victim_frame,
    output logic [$clog2(CAPACITY+1)-1:0]         list_size
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ENT_W = FRAME_ID_BITS + 1;

    logic [ENT_W-1:0]          slot_reg [CAPACITY];
    logic [ENT_W-1:0]          rdata_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          hand_reg, hand_next;
    logic                      hv_reg, hv_next;
    logic [CNT_W-1:0]          ptr_reg, ptr_next;
    logic [FRAME_ID_BITS-1:0]  fid_reg, fid_next;
    logic                      found_reg, found_next;
    logic [FRAME_ID_BITS-1:0]  victim_reg, victim_next;

    logic                      we;
    logic [CNT_W-1:0]          waddr;
    logic [ENT_W-1:0]          wdata;

    logic [CNT_W-1:0]          limit;
    logic [CNT_W-1:0]          hand_ext;
    logic [CNT_W-1:0]          hand_inc;
    logic [CNT_W-1:0]          hand_wrap;
    logic [CNT_W-1:0]          ins_pos;
    logic [CNT_W-1:0]          count_dec;

    always_comb
    begin
        if (capacity == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (32'(capacity) > CAPACITY)
        begin
            limit = CNT_W'(CAPACITY);
        end
        else
        begin
            limit = CNT_W'(capacity);
        end
    end

    assign hand_ext  = CNT_W'(hand_reg);
    assign hand_inc  = hand_ext + CNT_W'(1);
    assign hand_wrap = (hand_inc == count_reg) ? '0 : hand_inc;
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        ins_pos = hv_reg ? hand_ext : '0;
        if (ins_pos > count_reg)
        begin
            ins_pos = count_reg;
        end
    end

    assign st.cnt_zero  = (count_reg == '0);
    assign st.ref_set   = rdata_reg[ENT_W-1];
    assign st.match     = (rdata_reg[FRAME_ID_BITS-1:0] == fid_reg);
    assign st.src_last  = ({1'b0, ptr_reg} + (CNT_W+1)'(1)) >= {1'b0, count_reg};
    assign st.has_room  = (count_reg < limit);
    assign st.ins_empty = (count_reg == ins_pos);
    assign st.ins_at_h  = (ptr_reg == ins_pos);

    always_comb
    begin
        count_next  = count_reg;
        hand_next   = hand_reg;
        hv_next     = hv_reg;
        ptr_next    = ptr_reg;
        fid_next    = fid_reg;
        found_next  = found_reg;
        victim_next = victim_reg;
        we          = 1'b0;
        waddr       = ptr_reg;
        wdata       = rdata_reg;
        case (op)
            crp_pkg::OP_START:
            begin
                fid_next    = frame_num;
                found_next  = 1'b0;
                victim_next = '0;
                ptr_next    = '0;
            end
            crp_pkg::OP_EV_STEP:
            begin
                hand_next = hv_reg ? IDX_W'(hand_wrap) : '0;
                ptr_next  = hv_reg ? hand_wrap : '0;
                hv_next   = 1'b1;
            end
            crp_pkg::OP_EV_CLEAR:
            begin
                we        = 1'b1;
                waddr     = ptr_reg;
                wdata     = {1'b0, rdata_reg[FRAME_ID_BITS-1:0]};
                hand_next = IDX_W'(hand_wrap);
                ptr_next  = hand_wrap;
            end
            crp_pkg::OP_TAKE:
            begin
                found_next  = 1'b1;
                victim_next = rdata_reg[FRAME_ID_BITS-1:0];
            end
            crp_pkg::OP_INC:
            begin
                ptr_next = ptr_reg + CNT_W'(1);
            end
            crp_pkg::OP_SHIFT_DN:
            begin
                we       = 1'b1;
                waddr    = ptr_reg - CNT_W'(1);
                wdata    = rdata_reg;
                ptr_next = ptr_reg + CNT_W'(1);
            end
            crp_pkg::OP_FIX_VICTIM:
            begin
                count_next = count_dec;
                if (count_dec == '0)
                begin
                    hv_next   = 1'b0;
                    hand_next = '0;
                end
                else if (hand_reg == '0)
                begin
                    hand_next = IDX_W'(count_dec - CNT_W'(1));
                end
                else
                begin
                    hand_next = hand_reg - IDX_W'(1);
                end
            end
            crp_pkg::OP_FIX_PIN:
            begin
                count_next = count_dec;
                if (hv_reg && hand_ext == count_dec)
                begin
                    if (count_dec == '0)
                    begin
                        hv_next   = 1'b0;
                        hand_next = '0;
                    end
                    else
                    begin
                        hand_next = IDX_W'(count_dec - CNT_W'(1));
                    end
                end
            end
            crp_pkg::OP_SET_REF:
            begin
                we    = 1'b1;
                waddr = ptr_reg;
                wdata = {1'b1, fid_reg};
            end
            crp_pkg::OP_APPEND:
            begin
                we         = 1'b1;
                waddr      = count_reg;
                wdata      = {1'b1, fid_reg};
                count_next = count_reg + CNT_W'(1);
                hand_next  = hv_reg ? IDX_W'(hand_inc) : '0;
                hv_next    = 1'b1;
            end
            crp_pkg::OP_PTR_LAST:
            begin
                ptr_next = count_dec;
            end
            crp_pkg::OP_SHIFT_UP:
            begin
                we       = 1'b1;
                waddr    = ptr_reg + CNT_W'(1);
                wdata    = rdata_reg;
                ptr_next = ptr_reg - CNT_W'(1);
            end
            crp_pkg::OP_INSERT:
            begin
                we         = 1'b1;
                waddr      = ins_pos;
                wdata      = {1'b1, fid_reg};
                count_next = count_reg + CNT_W'(1);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_reg[waddr[IDX_W-1:0]] <= wdata;
        end
        rdata_reg <= slot_reg[ptr_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hand_reg  <= '0;
            hv_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            hand_reg  <= hand_next;
            hv_reg    <= hv_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        fid_reg    <= fid_next;
        victim_reg <= victim_next;
    end

    assign found        = found_reg;
    assign victim_frame = victim_reg;
    assign list_size    = count_reg;

endmodule

`default_nettype wire

// File: design/clock_page_replacer.sv
// ----------------------------------------------------------------------------
// clock_page_replacer
// Clock page replacement list with victim, pin, unpin and size operations.
// ----------------------------------------------------------------------------
// A command word is taken on func and frame_num when start is high and busy
// is low. Each command gives exactly one result word on found, victim_frame
// and list_size, marked by done for a single cycle. The receiver cannot
// stall; the result is taken in the cycle done is high.
// A size query answers in the cycle after it is taken. Other commands walk
// the slot memory one entry at a time, since its single read port has a
// registered output: a search reads entries up to the match, a removal or
// insertion reads and writes each shifted entry, and a victim sweep visits
// entries up to one full turn of the list plus one entry. The worst case
// is an unpin into a full list: a full search, a victim sweep, a removal
// and an insertion. The capacity register is written through the APB port;
// the user must write it only while idle; the block does not enforce this.
// Reset empties the list and parks the hand; the slot memory is not cleared,
// as only entries below the entry count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_page_replacer
#(
    parameter int CAPACITY      = 64,
    parameter int FRAME_ID_BITS = 10
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    func,
    input  wire logic [FRAME_ID_BITS-1:0]      frame_num,
    output logic                               done,
    output logic                               found,
    output logic [FRAME_ID_BITS-1:0]           victim_frame,
    output logic [$clog2(CAPACITY+1)-1:0]      list_size,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [crp_pkg::CFG_WIDTH-1:0] capacity_reg, capacity_next;
    crp_pkg::dp_op_t               op;
    crp_pkg::dp_status_t           st;

    always_comb
    begin
        capacity_next = capacity_reg;
        if (psel && penable && pwrite && paddr[2] == crp_pkg::REG_CAPACITY)
        begin
            capacity_next = pwdata[crp_pkg::CFG_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= crp_pkg::CFG_CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == crp_pkg::REG_CAPACITY) ? 32'(capacity_reg) : '0;

    crp_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (func),
        .st    (st),
        .busy  (busy),
        .done  (done),
        .op    (op)
    );

    crp_datapath
    #(
        .CAPACITY      (CAPACITY),
        .FRAME_ID_BITS (FRAME_ID_BITS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .frame_num    (frame_num),
        .capacity     (capacity_reg),
        .st           (st),
        .found        (found),
        .victim_frame (victim_frame),
        .list_size    (list_size)
    );

endmodule

`default_nettype wire

// File: design/crp_checker.sv
// ----------------------------------------------------------------------------
// crp_checker
// Port-level checks of the clock page replacer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crp_checker
#(
    parameter int CAPACITY = 64
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [1:0]                    func,
    input wire logic                          done,
    input wire logic                          found,
    input wire logic [$clog2(CAPACITY+1)-1:0] list_size,
    input wire logic                          pready
);

    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result word without a command in progress");

    a_size_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == crp_pkg::FUNC_SIZE) |=> (done && !busy))
        else $error("size query did not answer in one cycle");

    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(list_size) <= CAPACITY))
        else $error("list size beyond capacity");

    a_evict_leaves_room: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (32'(list_size) < CAPACITY))
        else $error("eviction left a full list");

    a_ready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind clock_page_replacer crp_checker #(.CAPACITY(CAPACITY)) u_crp_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .done      (done),
    .found     (found),
    .list_size (list_size),
    .pready    (pready)
);

`default_nettype wire
